FILE: sv/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Shared constants, microcode word layout and helpers for the radix digit
// emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 64;
  localparam int MAX_RADIX   = 16;

  localparam int DATA_W  = 64;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 5;

  localparam int CHUNKS = (VALUE_WIDTH + 7) / 8;
  localparam int QW     = CHUNKS * 8;
  localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int AW     = $clog2(MAX_DIGITS);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HI = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;
  localparam logic [CFG_W-1:0]   CHARS_LO_RST = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0]   CHARS_HI_RST = 64'h6665_6463_6261_3938;

  localparam int STEP_W = 3;

  localparam logic [1:0] COND_ALWAYS      = 2'd0;
  localparam logic [1:0] COND_CHUNK_MORE  = 2'd1;
  localparam logic [1:0] COND_MORE_DIGITS = 2'd2;
  localparam logic [1:0] COND_NOT_LAST    = 2'd3;

  typedef struct packed {
    logic              wait_in;
    logic              wait_out;
    logic              load;
    logic              div;
    logic              push;
    logic              rd;
    logic              emit;
    logic [1:0]        cond;
    logic [STEP_W-1:0] tgt_t;
    logic [STEP_W-1:0] tgt_f;
  } uword_t;

  typedef struct packed {
    logic load;
    logic div;
    logic push;
    logic rd;
    logic emit;
  } act_t;

  typedef struct packed {
    logic chunk_last;
    logic more_digits;
    logic pos_zero;
  } stat_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_W'(2)) res = RADIX_W'(2);
    else if (r > RADIX_W'(MAX_RADIX)) res = RADIX_W'(MAX_RADIX);
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char_of(input logic [DIGIT_W-1:0] d,
                                                      input logic [CFG_W-1:0] lo,
                                                      input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] word;
    word = d[3] ? hi : lo;
    return word[d[2:0]*8 +: 8];
  endfunction

endpackage

FILE: sv/rde_seq.sv
// ----------------------------------------------------------------------------
// rde_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module rde_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           out_free,
  input  rde_pkg::stat_t stat,
  output logic           s_tready,
  output rde_pkg::act_t  act
);
  import rde_pkg::*;

  localparam logic [STEP_W-1:0] S_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] S_DIV  = 3'd1;
  localparam logic [STEP_W-1:0] S_PUSH = 3'd2;
  localparam logic [STEP_W-1:0] S_RD   = 3'd3;
  localparam logic [STEP_W-1:0] S_EMIT = 3'd4;

  function automatic uword_t ucode(input logic [STEP_W-1:0] s);
    uword_t w;
    w = '0;
    unique case (s)
      S_IDLE: begin
        w.wait_in = 1'b1; w.load = 1'b1;
        w.cond = COND_ALWAYS; w.tgt_t = S_DIV; w.tgt_f = S_DIV;
      end
      S_DIV: begin
        w.div = 1'b1;
        w.cond = COND_CHUNK_MORE; w.tgt_t = S_DIV; w.tgt_f = S_PUSH;
      end
      S_PUSH: begin
        w.push = 1'b1;
        w.cond = COND_MORE_DIGITS; w.tgt_t = S_DIV; w.tgt_f = S_RD;
      end
      S_RD: begin
        w.rd = 1'b1;
        w.cond = COND_ALWAYS; w.tgt_t = S_EMIT; w.tgt_f = S_EMIT;
      end
      S_EMIT: begin
        w.wait_out = 1'b1; w.emit = 1'b1;
        w.cond = COND_NOT_LAST; w.tgt_t = S_RD; w.tgt_f = S_IDLE;
      end
      default: begin
        w.cond = COND_ALWAYS; w.tgt_t = S_IDLE; w.tgt_f = S_IDLE;
      end
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  uword_t            uw;
  logic              go;
  logic              taken;

  assign uw       = ucode(step);
  assign s_tready = uw.wait_in;
  assign go       = !(uw.wait_in && !s_tvalid) && !(uw.wait_out && !out_free);

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:      taken = 1'b1;
      COND_CHUNK_MORE:  taken = !stat.chunk_last;
      COND_MORE_DIGITS: taken = stat.more_digits;
      COND_NOT_LAST:    taken = !stat.pos_zero;
      default:          taken = 1'b1;
    endcase
  end

  assign step_next = !go ? step : (taken ? uw.tgt_t : uw.tgt_f);

  assign act.load = go && uw.load;
  assign act.div  = go && uw.div;
  assign act.push = go && uw.push;
  assign act.rd   = go && uw.rd;
  assign act.emit = go && uw.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: sv/rde_datapath.sv
// ----------------------------------------------------------------------------
// rde_datapath
// Quotient register with an 8-bit-per-cycle radix divider, digit stack
// memory and digit counters.
// ----------------------------------------------------------------------------
module rde_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rde_pkg::act_t                 act,
  input  logic [rde_pkg::DATA_W-1:0]    value,
  input  logic [rde_pkg::RADIX_W-1:0]   radix_eff,
  output rde_pkg::stat_t                stat,
  output logic [rde_pkg::DIGIT_W-1:0]   rd_digit
);
  import rde_pkg::*;

  logic [QW-1:0]      q;
  logic [DIGIT_W-1:0] rem;
  logic [CH_W-1:0]    chunk;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   pos_dec;
  logic [DIGIT_W-1:0] stack [MAX_DIGITS];

  logic [7:0]         top;
  logic [7:0]         qbits;
  logic [DIGIT_W-1:0] rem_next;
  logic [RADIX_W-1:0] t;

  assign top     = q[QW-1 -: 8];
  assign pos_dec = pos - CNT_W'(1);

  always_comb begin
    t        = '0;
    qbits    = '0;
    rem_next = rem;
    for (int i = 7; i >= 0; i--) begin
      t = {rem_next, top[i]};
      if (t >= radix_eff) begin
        qbits[i] = 1'b1;
        rem_next = DIGIT_W'(t - radix_eff);
      end else begin
        rem_next = t[DIGIT_W-1:0];
      end
    end
  end

  assign stat.chunk_last  = (chunk == CH_W'(CHUNKS - 1));
  assign stat.more_digits = (q != '0) && (count != CNT_W'(MAX_DIGITS - 1));
  assign stat.pos_zero    = (pos == '0);

  always_ff @(posedge clk) begin
    if (act.load) begin
      q   <= QW'(value[VALUE_WIDTH-1:0]);
      rem <= '0;
    end else if (act.div) begin
      q   <= (q << 8) | QW'(qbits);
      rem <= rem_next;
    end else if (act.push) begin
      rem <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= '0;
      count <= '0;
      pos   <= '0;
    end else begin
      if (act.load) begin
        chunk <= '0;
        count <= '0;
      end else if (act.div) begin
        chunk <= stat.chunk_last ? '0 : chunk + CH_W'(1);
      end else if (act.push) begin
        chunk <= '0;
        count <= count + CNT_W'(1);
        pos   <= count + CNT_W'(1);
      end else if (act.rd) begin
        pos <= pos_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act.push) begin
      stack[count[AW-1:0]] <= rem;
    end
    if (act.rd) begin
      rd_digit <= stack[pos_dec[AW-1:0]];
    end
  end

endmodule

FILE: sv/radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts an unsigned value to its digit characters in a configured radix,
// most significant digit first, last digit flagged.
//
//   Channel  Dir  Signals                       Content
//   s_*      in   tvalid tready tdata[63:0]     value
//   m_*      out  tvalid tready tdata[7:0] tlast digit_char, last_digit
//   cfg_*    in   we index[1:0] wdata[63:0]     radix, char table low/high
//
// A value is accepted, then each digit is divided out (8 quotient bits per
// cycle through one compare/subtract chain) and pushed on the digit stack,
// which is then replayed. Reset is synchronous; no clearing pass. A stalled
// output holds the sequencer in its emit step; the next value is taken while
// the final digit still waits in the output register.
// ----------------------------------------------------------------------------
module radix_digit_emitter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rde_pkg::DATA_W-1:0]        s_tdata,   // [63:0] value
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rde_pkg::CHAR_W-1:0]        m_tdata,   // [7:0] digit_char
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [rde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rde_pkg::CFG_W-1:0]         cfg_wdata
);
  import rde_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic [CFG_W-1:0]   chars_lo;
  logic [CFG_W-1:0]   chars_hi;
  logic [RADIX_W-1:0] radix_eff;
  logic               out_free;
  act_t               act;
  stat_t              stat;
  logic [DIGIT_W-1:0] rd_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix    <= RADIX_RST;
      chars_lo <= CHARS_LO_RST;
      chars_hi <= CHARS_HI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIX:    radix    <= cfg_wdata[RADIX_W-1:0];
        CFG_CHARS_LO: chars_lo <= cfg_wdata;
        CFG_CHARS_HI: chars_hi <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign radix_eff = eff_radix(radix);
  assign out_free  = !m_tvalid || m_tready;

  rde_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .s_tready (s_tready),
    .act      (act)
  );

  rde_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .act       (act),
    .value     (s_tdata),
    .radix_eff (radix_eff),
    .stat      (stat),
    .rd_digit  (rd_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (act.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act.emit) begin
      m_tdata <= digit_char_of(rd_digit, chars_lo, chars_hi);
      m_tlast <= stat.pos_zero;
    end
  end

  // one value in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second value accepted during conversion");

  // stack replay never reads below the bottom entry
  a_rd_bounds: assert property (@(posedge clk) disable iff (rst)
    act.rd |-> !stat.pos_zero)
    else $error("digit stack read past bottom");

  // final digit returns the sequencer to accept a new value
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (act.emit && stat.pos_zero) |=> s_tready)
    else $error("sequencer not idle after final digit");

  // digits are only emitted when the output slot can take them
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    act.emit |-> out_free)
    else $error("digit emitted into occupied output register");

endmodule
